### src/svog_pkg.sv
// ----------------------------------------------------------------------------
// svog_pkg
// Shared types and constants of the strided view offset generator.
// ----------------------------------------------------------------------------
`default_nettype none

package svog_pkg;

  localparam int NUM_SLOTS     = 4;
  localparam int IDX_W         = 16;
  localparam int NUM_W         = 32;
  localparam int STRIDE_W      = 24;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int PROD_W        = IDX_W + STRIDE_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int STEPS_PER_DIM = NUM_W;
  localparam int NUM_STEPS     = NUM_SLOTS * STEPS_PER_DIM;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    ACT_INDICES = 1'b0,
    ACT_LINEAR  = 1'b1
  } action_e;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE0 = 3'd4;

  typedef struct packed {
    logic [NUM_SLOTS-1:0][IDX_W-1:0]    ext;     // effective extents
    logic [NUM_SLOTS-1:0][STRIDE_W-1:0] stride;
  } cfg_t;

  // item traveling through the split pipeline
  typedef struct packed {
    logic                            act;
    logic                            bad;
    logic [NUM_SLOTS-1:0][IDX_W-1:0] idx;
    logic [NUM_W-1:0]                num;  // dividend bits high, quotient bits low
    logic [IDX_W-1:0]                rem;
  } item_t;

endpackage

`default_nettype wire

### src/svog_in_if.sv
// ----------------------------------------------------------------------------
// svog_in_if
// Request channel: access by indices or by linear element number.
// ----------------------------------------------------------------------------
`default_nettype none

interface svog_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] index_dim0;
  logic [15:0] index_dim1;
  logic [15:0] index_dim2;
  logic [15:0] index_dim3;
  logic [31:0] element_number;

  modport source (output valid, action, index_dim0, index_dim1, index_dim2, index_dim3,
                  element_number, input ready);
  modport sink   (input valid, action, index_dim0, index_dim1, index_dim2, index_dim3,
                  element_number, output ready);
endinterface

`default_nettype wire

### src/svog_out_if.sv
// ----------------------------------------------------------------------------
// svog_out_if
// Result channel: storage offset and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface svog_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] offset;
  logic [1:0]  status;

  modport source (output valid, offset, status, input ready);
  modport sink   (input valid, offset, status, output ready);
endinterface

`default_nettype wire

### src/svog_cfg.sv
// ----------------------------------------------------------------------------
// svog_cfg
// Shape and stride registers; derives effective extents.
// ----------------------------------------------------------------------------
`default_nettype none

module svog_cfg #(
  parameter int NUM_DIMS = 4
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             we_i,
  input  wire [svog_pkg::CFG_IDX_W-1:0]   idx_i,
  input  wire [svog_pkg::CFG_W-1:0]       data_i,
  output svog_pkg::cfg_t                  cfg_o
);
  import svog_pkg::*;

  localparam int ACTIVE = (NUM_DIMS > NUM_SLOTS) ? NUM_SLOTS : ((NUM_DIMS < 1) ? 1 : NUM_DIMS);

  logic [NUM_SLOTS-1:0][IDX_W-1:0]    shape_q;
  logic [NUM_SLOTS-1:0][STRIDE_W-1:0] stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NUM_SLOTS; d++) begin
        shape_q[d]  <= IDX_W'(1);
        stride_q[d] <= STRIDE_W'(1);
      end
    end else if (we_i) begin
      if (idx_i <= REG_SHAPE3) begin
        shape_q[idx_i[1:0]] <= data_i[IDX_W-1:0];
      end else begin
        stride_q[idx_i[1:0]] <= data_i[STRIDE_W-1:0];
      end
    end
  end

  // leading inactive slots act as extent 1
  always_comb begin
    for (int d = 0; d < NUM_SLOTS; d++) begin
      cfg_o.ext[d]    = (d < NUM_SLOTS - ACTIVE) ? IDX_W'(1) : shape_q[d];
      cfg_o.stride[d] = stride_q[d];
    end
  end

endmodule

`default_nettype wire

### src/svog_split.sv
// ----------------------------------------------------------------------------
// svog_split
// Pipelined restoring division: linear number into indices, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module svog_split (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   adv_i,
  input  svog_pkg::cfg_t        cfg_i,
  input  wire                   vld_i,
  input  svog_pkg::item_t       item_i,
  output logic                  vld_o,
  output svog_pkg::item_t       item_o
);
  import svog_pkg::*;

  logic  [NUM_STEPS:0] vld_q;
  item_t               stg_q [NUM_STEPS+1];

  assign vld_q[0] = vld_i;
  assign stg_q[0] = item_i;

  for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
    localparam int D = NUM_SLOTS - 1 - s / STEPS_PER_DIM;
    localparam int B = s % STEPS_PER_DIM;

    logic [IDX_W-1:0] div;
    logic [IDX_W:0]   trial;
    logic             fit;
    item_t            nxt_d;

    always_comb begin
      nxt_d = stg_q[s];
      // zero extent: flag it and divide by one, leaving the number unchanged
      div   = (cfg_i.ext[D] == '0) ? IDX_W'(1) : cfg_i.ext[D];
      trial = {((B == 0) ? IDX_W'(0) : stg_q[s].rem), stg_q[s].num[NUM_W-1]};
      fit   = (trial >= {1'b0, div});
      nxt_d.rem = fit ? IDX_W'(trial - {1'b0, div}) : trial[IDX_W-1:0];
      nxt_d.num = {stg_q[s].num[NUM_W-2:0], fit};
      if (B == 0 && stg_q[s].act == ACT_LINEAR && cfg_i.ext[D] == '0) begin
        nxt_d.bad = 1'b1;
      end
      if (B == STEPS_PER_DIM - 1 && stg_q[s].act == ACT_LINEAR) begin
        nxt_d.idx[D] = nxt_d.rem;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        stg_q[s+1] <= nxt_d;
      end
    end
  end

  assign vld_o  = vld_q[NUM_STEPS];
  assign item_o = stg_q[NUM_STEPS];

endmodule

`default_nettype wire

### src/svog_offset.sv
// ----------------------------------------------------------------------------
// svog_offset
// Index times stride products, then sum, overflow check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module svog_offset (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      adv_i,
  input  svog_pkg::cfg_t           cfg_i,
  input  wire                      vld_i,
  input  svog_pkg::item_t          item_i,
  output logic                     vld_o,
  output logic [svog_pkg::NUM_W-1:0] offset_o,
  output svog_pkg::status_e        status_o
);
  import svog_pkg::*;

  logic                               prd_vld_q;
  logic                               prd_bad_q;
  logic [NUM_SLOTS-1:0][PROD_W-1:0]   prd_q;
  logic [SUM_W-1:0]                   sum;

  // leftover quotient after the outermost split means out of range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_vld_q <= 1'b0;
      vld_o     <= 1'b0;
    end else if (adv_i) begin
      prd_vld_q <= vld_i;
      vld_o     <= prd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prd_bad_q <= item_i.bad | ((item_i.act == ACT_LINEAR) && (item_i.num != '0));
      for (int d = 0; d < NUM_SLOTS; d++) begin
        prd_q[d] <= PROD_W'(item_i.idx[d]) * PROD_W'(cfg_i.stride[d]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int d = 0; d < NUM_SLOTS; d++) begin
      sum = sum + SUM_W'(prd_q[d]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (prd_bad_q) begin
        offset_o <= '0;
        status_o <= STATUS_RANGE;
      end else if (sum[SUM_W-1:NUM_W] != '0) begin
        offset_o <= '0;
        status_o <= STATUS_OVERFLOW;
      end else begin
        offset_o <= sum[NUM_W-1:0];
        status_o <= STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

### src/strided_view_offset_generator.sv
// ----------------------------------------------------------------------------
// strided_view_offset_generator
// Element request on a 4-D strided view -> storage element offset.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_if    in   valid/ready    action, index_dim0..3, element_number
//  out_if   out  valid/ready    offset, status
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i (no read-back)
//
//  One item per cycle while the result stage is not stalled; one input stage with
//  the index range check, 128 divide stages (one quotient bit per stage,
//  32 per dimension), one multiply stage, one sum/status stage.
//  Reset clears all valid bits; shapes and strides reset to 1.
//  The whole pipe moves together; it holds when the result stage is full
//  and not taken, so a stall drops nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_view_offset_generator #(
  parameter int NUM_DIMS = 4
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [svog_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [svog_pkg::CFG_W-1:0]      cfg_data_i,
  svog_in_if.sink                        in_if,
  svog_out_if.source                     out_if
);
  import svog_pkg::*;

  cfg_t              cfg;
  logic              adv;
  logic              in_vld_q;
  item_t             in_item_q;
  item_t             in_item_d;
  logic              spl_vld;
  item_t             spl_item;
  status_e           status;
  logic [IDX_W-1:0]  in_idx [NUM_SLOTS];

  // pipe advances unless a finished result is stuck
  assign adv         = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  svog_cfg #(.NUM_DIMS(NUM_DIMS)) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign in_idx[0] = in_if.index_dim0;
  assign in_idx[1] = in_if.index_dim1;
  assign in_idx[2] = in_if.index_dim2;
  assign in_idx[3] = in_if.index_dim3;

  // input stage: index mode checks bounds here; linear mode starts the split
  always_comb begin
    in_item_d.act = in_if.action;
    in_item_d.bad = 1'b0;
    in_item_d.num = in_if.element_number;
    in_item_d.rem = '0;
    for (int d = 0; d < NUM_SLOTS; d++) begin
      in_item_d.idx[d] = in_idx[d];
      if (in_if.action == ACT_INDICES && in_idx[d] >= cfg.ext[d]) begin
        in_item_d.bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_item_q <= in_item_d;
    end
  end

  svog_split u_split (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg),
    .vld_i  (in_vld_q),
    .item_i (in_item_q),
    .vld_o  (spl_vld),
    .item_o (spl_item)
  );

  svog_offset u_offset (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .cfg_i    (cfg),
    .vld_i    (spl_vld),
    .item_i   (spl_item),
    .vld_o    (out_if.valid),
    .offset_o (out_if.offset),
    .status_o (status)
  );

  assign out_if.status = status;

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == (!out_if.valid || out_if.ready))
    else $error("ready does not follow the result stage");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.status == STATUS_OK || out_if.status == STATUS_RANGE ||
                      out_if.status == STATUS_OVERFLOW))
    else $error("undefined status code");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status != STATUS_OK) |-> (out_if.offset == '0))
    else $error("nonzero offset on a fault");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.offset)))
    else $error("result lost during stall");

endmodule

`default_nettype wire
